FILE: design/tgau_pkg.sv
// Shared types and constants for the TGA true-color unpacker.
package tgau_pkg;

  // Header byte positions within the 18-byte file header.
  localparam logic [4:0] HDR_COLORMAP_TYPE = 5'd1;
  localparam logic [4:0] HDR_IMAGE_TYPE    = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO      = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI      = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO     = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI     = 5'd15;
  localparam logic [4:0] HDR_DEPTH         = 5'd16;
  localparam logic [4:0] HDR_DESCRIPTOR    = 5'd17;

  localparam logic [7:0] IMAGE_TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] DEPTH_24            = 8'd24;
  localparam logic [7:0] DEPTH_32            = 8'd32;
  localparam int         DESC_TOP_DOWN_BIT   = 5;

  // Depth of the queue between the parser and the pixel assembler.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PIXEL         = 2'd0,
    KIND_HEADER_OK     = 2'd1,
    KIND_HEADER_REJECT = 2'd2
  } kind_t;

  typedef enum logic {
    OP_HEADER     = 1'b0,
    OP_PIXEL_BYTE = 1'b1
  } op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } byte_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        with_alpha;
    logic [15:0] width;
    logic [15:0] height;
    logic        last;
  } result_beat_t;

  // One queue entry: either a finished header or one pixel data byte.
  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        accept;
    logic        empty;
    logic        with_alpha;
    logic        top_down;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] row_base;
  } entry_t;

endpackage

FILE: design/tgau_front.sv
// Header parser: checks the header, skips the ID field and forwards pixel bytes.
module tgau_front (
  input  logic                byte_valid,
  input  tgau_pkg::byte_beat_t byte_beat,
  input  logic                queue_full,
  input  logic                clk,
  input  logic                rst,
  output logic                push,
  output tgau_pkg::entry_t    entry
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SKIP,
    ST_PIX,
    ST_DONE
  } state_t;

  state_t      state;
  logic [4:0]  header_count;
  logic [7:0]  id_length;
  logic [7:0]  skip_left;
  logic        rejected;
  logic        depth32;
  logic [15:0] image_width;
  logic [15:0] image_height;

  logic        take;
  logic        at_descriptor;
  logic        empty;
  logic        top_down;
  logic [15:0] height_m1;
  logic [31:0] bottom_base;
  logic [7:0]  b;

  assign b    = byte_beat.data_byte;
  assign take = byte_valid && !queue_full;

  always_comb begin
    at_descriptor = (state == ST_HEAD) && (header_count == tgau_pkg::HDR_DESCRIPTOR);
    empty         = (image_width == 16'd0) || (image_height == 16'd0);
    top_down      = b[tgau_pkg::DESC_TOP_DOWN_BIT];
    height_m1     = image_height - 16'd1;
    bottom_base   = {16'd0, height_m1} * {16'd0, image_width};

    push = take && !byte_beat.first_byte && (at_descriptor || (state == ST_PIX));

    entry.op         = at_descriptor ? tgau_pkg::OP_HEADER : tgau_pkg::OP_PIXEL_BYTE;
    entry.data       = b;
    entry.accept     = !rejected;
    entry.empty      = empty;
    entry.with_alpha = depth32 && !rejected;
    entry.top_down   = top_down;
    entry.width      = image_width;
    entry.height     = image_height;
    entry.row_base   = top_down ? 32'd0 : bottom_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      header_count <= 5'd0;
      id_length    <= 8'd0;
      skip_left    <= 8'd0;
      rejected     <= 1'b0;
      depth32      <= 1'b0;
      image_width  <= 16'd0;
      image_height <= 16'd0;
    end else if (take) begin
      if (byte_beat.first_byte) begin
        state        <= ST_HEAD;
        header_count <= 5'd1;
        id_length    <= b;
        rejected     <= 1'b0;
        depth32      <= 1'b0;
        image_width  <= 16'd0;
        image_height <= 16'd0;
      end else begin
        unique case (state)
          ST_HEAD: begin
            header_count <= header_count + 5'd1;
            unique case (header_count)
              tgau_pkg::HDR_COLORMAP_TYPE: if (b != 8'd0) rejected <= 1'b1;
              tgau_pkg::HDR_IMAGE_TYPE: begin
                if (b != tgau_pkg::IMAGE_TYPE_TRUECOLOR) rejected <= 1'b1;
              end
              tgau_pkg::HDR_WIDTH_LO:  image_width[7:0]   <= b;
              tgau_pkg::HDR_WIDTH_HI:  image_width[15:8]  <= b;
              tgau_pkg::HDR_HEIGHT_LO: image_height[7:0]  <= b;
              tgau_pkg::HDR_HEIGHT_HI: image_height[15:8] <= b;
              tgau_pkg::HDR_DEPTH: begin
                depth32 <= (b == tgau_pkg::DEPTH_32);
                if ((b != tgau_pkg::DEPTH_24) && (b != tgau_pkg::DEPTH_32)) begin
                  rejected <= 1'b1;
                end
              end
              tgau_pkg::HDR_DESCRIPTOR: begin
                if (rejected || empty) begin
                  state <= ST_DONE;
                end else if (id_length != 8'd0) begin
                  skip_left <= id_length;
                  state     <= ST_SKIP;
                end else begin
                  state <= ST_PIX;
                end
              end
              default: ;
            endcase
          end
          ST_SKIP: begin
            skip_left <= skip_left - 8'd1;
            if (skip_left == 8'd1) state <= ST_PIX;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: design/tgau_queue.sv
// Two-entry queue that decouples the header parser from the pixel assembler.
module tgau_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tgau_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             head_valid,
  output tgau_pkg::entry_t head_entry,
  output logic             full
);

  tgau_pkg::entry_t                   slots [tgau_pkg::QUEUE_DEPTH];
  logic [tgau_pkg::PTR_W-1:0]         wr_ptr;
  logic [tgau_pkg::PTR_W-1:0]         rd_ptr;
  logic [tgau_pkg::COUNT_W-1:0]       count;
  logic                               do_pop;

  assign head_valid = (count != '0);
  assign full       = (count == tgau_pkg::COUNT_W'(tgau_pkg::QUEUE_DEPTH));
  assign head_entry = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tgau_pkg::PTR_W'(tgau_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  wr_ptr + tgau_pkg::PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == tgau_pkg::PTR_W'(tgau_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  rd_ptr + tgau_pkg::PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + tgau_pkg::COUNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - tgau_pkg::COUNT_W'(1);
      end
    end
  end

endmodule

FILE: design/tgau_back.sv
// Pixel assembler: gathers BGR(A) groups, tracks row addressing and drives results.
module tgau_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  tgau_pkg::entry_t      head_entry,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output tgau_pkg::result_beat_t result_beat
);

  logic        active;
  logic [1:0]  group_position;
  logic [7:0]  held_blue;
  logic [7:0]  held_green;
  logic [7:0]  held_red;
  logic [15:0] column;
  logic [15:0] rows_left;
  logic [31:0] row_base;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        with_alpha;
  logic        top_down;

  logic        slot_free;
  logic        header_pop;
  logic        is_pixel_byte;
  logic        group_done;
  logic [15:0] column_inc;
  logic        row_end;
  logic [15:0] rows_dec;
  logic [31:0] pixel_index;
  logic [31:0] next_row_base;
  logic [7:0]  b;

  assign slot_free = !result_valid || !result_stall;
  assign pop       = head_valid && slot_free;
  assign b         = head_entry.data;

  always_comb begin
    header_pop    = pop && (head_entry.op == tgau_pkg::OP_HEADER);
    is_pixel_byte = pop && (head_entry.op == tgau_pkg::OP_PIXEL_BYTE) && active;
    group_done    = is_pixel_byte &&
                    (((group_position == 2'd2) && !with_alpha) || (group_position == 2'd3));
    column_inc    = column + 16'd1;
    row_end       = (column_inc == image_width);
    rows_dec      = rows_left - 16'd1;
    pixel_index   = row_base + {16'd0, column};
    next_row_base = top_down ? row_base + {16'd0, image_width} :
                               row_base - {16'd0, image_width};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      group_position <= 2'd0;
      result_valid   <= 1'b0;
    end else begin
      // The output register refills only once its beat has been taken.
      if (slot_free) result_valid <= header_pop || group_done;

      if (header_pop) begin
        active         <= head_entry.accept && !head_entry.empty;
        group_position <= 2'd0;
        column         <= 16'd0;
        rows_left      <= head_entry.height;
        row_base       <= head_entry.row_base;
        image_width    <= head_entry.width;
        image_height   <= head_entry.height;
        with_alpha     <= head_entry.with_alpha;
        top_down       <= head_entry.top_down;

        result_beat.kind         <= head_entry.accept ? tgau_pkg::KIND_HEADER_OK :
                                                        tgau_pkg::KIND_HEADER_REJECT;
        result_beat.pixel_index  <= 32'd0;
        result_beat.red          <= 8'd0;
        result_beat.green        <= 8'd0;
        result_beat.blue         <= 8'd0;
        result_beat.alpha        <= 8'd0;
        result_beat.with_alpha   <= head_entry.with_alpha;
        result_beat.width        <= head_entry.width;
        result_beat.height       <= head_entry.height;
        result_beat.last         <= !head_entry.accept || head_entry.empty;
      end

      if (is_pixel_byte) begin
        unique case (group_position)
          2'd0: begin
            held_blue      <= b;
            group_position <= 2'd1;
          end
          2'd1: begin
            held_green     <= b;
            group_position <= 2'd2;
          end
          2'd2: begin
            held_red       <= b;
            group_position <= with_alpha ? 2'd3 : 2'd0;
          end
          default: group_position <= 2'd0;
        endcase
      end

      if (group_done) begin
        if (row_end) begin
          column    <= 16'd0;
          rows_left <= rows_dec;
          row_base  <= next_row_base;
          if (rows_dec == 16'd0) active <= 1'b0;
        end else begin
          column <= column_inc;
        end

        result_beat.kind        <= tgau_pkg::KIND_PIXEL;
        result_beat.pixel_index <= pixel_index;
        result_beat.red         <= (group_position == 2'd2) ? b : held_red;
        result_beat.green       <= held_green;
        result_beat.blue        <= held_blue;
        result_beat.alpha       <= (group_position == 2'd3) ? b : 8'd0;
        result_beat.with_alpha  <= with_alpha;
        result_beat.width       <= image_width;
        result_beat.height      <= image_height;
        result_beat.last        <= row_end && (rows_dec == 16'd0);
      end
    end
  end

endmodule

FILE: design/tga_truecolor_unpacker.sv
// Top level of the TGA true-color unpacker: parser, queue and pixel assembler.
//
// The block takes a TGA file one byte per beat on the byte channel and sustains one byte
// per clock cycle while byte_stall is low. A beat with first_byte set starts a new file
// and abandons any file in progress. The parser checks the 18-byte header (no color map,
// image type 2, depth 24 or 32) and, after the descriptor byte, sends one header beat:
// kind header accepted with width, height and with_alpha, or kind header rejected with
// last set. An accepted header whose width or height is zero also carries last. The ID
// field is skipped, then every BGR or BGRA group yields one pixel beat with its
// destination index row * width + column, rows running bottom-up unless descriptor bit 5
// is set; the final pixel carries last. Bytes outside a file, after a rejection, after an
// empty header and after the final pixel are taken and dropped. The byte that completes a
// result is written into the two-entry queue between parser and assembler, and the
// assembler then loads the result into the output register, from which the result beat is
// taken. While the result side stalls, the queue still takes two more entries before the
// byte side stalls. The starting row base for bottom-up images comes from one 16 by 16 bit
// multiplier of (height - 1) by width at the descriptor byte.
module tga_truecolor_unpacker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  tgau_pkg::byte_beat_t   byte_beat,
  output logic                   result_valid,
  input  logic                   result_stall,
  output tgau_pkg::result_beat_t result_beat
);

  logic             push;
  tgau_pkg::entry_t push_entry;
  logic             pop;
  logic             head_valid;
  tgau_pkg::entry_t head_entry;
  logic             queue_full;

  // The byte side waits only while the queue holds as many entries as it can.
  assign byte_stall = queue_full;

  tgau_front u_front (
    .byte_valid (byte_valid),
    .byte_beat  (byte_beat),
    .queue_full (queue_full),
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .entry      (push_entry)
  );

  tgau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .full       (queue_full)
  );

  tgau_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

endmodule

FILE: test/tga_truecolor_unpacker_test.sv
// Self-checking testbench for the TGA true-color unpacker.
module tga_truecolor_unpacker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tgau_pkg::*;

  // Roughly how many byte beats the run offers before stimulus stops.
  localparam int TARGET_BYTES = 1650;

  // Parser progress through one file, as the predictor tracks it.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_SKIP,
    ST_PIXELS,
    ST_DONE
  } parse_state_t;

  // The scoreboard carries its own copy of the parser state. Every accepted byte beat
  // is run through it, and any header or pixel that the byte completes is queued as
  // the result the block must send next.
  class pixel_scoreboard;
    parse_state_t state;
    logic [4:0]   header_count;
    logic [7:0]   id_length;
    logic [7:0]   skip_left;
    logic [5:0]   bits_per_pixel;
    logic         top_down;
    logic         rejected;
    logic [15:0]  image_width;
    logic [15:0]  image_height;
    logic [15:0]  column;
    logic [15:0]  rows_left;
    logic [31:0]  row_base;
    logic [1:0]   group_position;
    logic [7:0]   held_blue;
    logic [7:0]   held_green;
    logic [7:0]   held_red;
    result_beat_t expected_results[$];
    int           mismatches;
    int           results_checked;
    int           headers_accepted;
    int           headers_rejected;
    int           pixels_expected;

    function new();
      clear();
    endfunction

    function void clear();
      state          = ST_IDLE;
      header_count   = '0;
      id_length      = '0;
      skip_left      = '0;
      bits_per_pixel = '0;
      top_down       = 1'b0;
      rejected       = 1'b0;
      image_width    = '0;
      image_height   = '0;
      column         = '0;
      rows_left      = '0;
      row_base       = '0;
      group_position = '0;
      held_blue      = '0;
      held_green     = '0;
      held_red       = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic alpha_on();
      return {2'b00, bits_per_pixel} == DEPTH_32;
    endfunction

    function void queue_result(kind_t k, logic [31:0] idx, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b, logic [7:0] a, logic ha, logic lst);
      result_beat_t res;
      res.kind        = k;
      res.pixel_index = idx;
      res.red         = r;
      res.green       = g;
      res.blue        = b;
      res.alpha       = a;
      res.with_alpha  = ha;
      res.width       = image_width;
      res.height      = image_height;
      res.last        = lst;
      expected_results.push_back(res);
    endfunction

    // Bottom-up files begin at the last row of the destination image.
    function void start_pixels();
      column         = '0;
      group_position = '0;
      rows_left      = image_height;
      if (top_down) begin
        row_base = '0;
      end else begin
        row_base = (32'(image_height) - 32'd1) * 32'(image_width);
      end
      state = ST_PIXELS;
    endfunction

    // Returns 1 when the byte is consumed by the parser rather than dropped.
    function logic note_byte(byte_beat_t beat);
      logic [7:0]  d;
      logic [4:0]  pos;
      logic [7:0]  alpha_byte;
      logic [31:0] idx;
      logic        final_pixel;
      logic        empty_image;
      d = beat.data_byte;
      if (beat.first_byte) begin
        clear();
        id_length    = d;
        header_count = 5'd1;
        state        = ST_HEADER;
        return 1'b1;
      end
      case (state)
        ST_HEADER: begin
          pos          = header_count;
          header_count = header_count + 5'd1;
          case (pos)
            HDR_COLORMAP_TYPE: if (d != 8'd0) rejected = 1'b1;
            HDR_IMAGE_TYPE:    if (d != IMAGE_TYPE_TRUECOLOR) rejected = 1'b1;
            HDR_WIDTH_LO:      image_width[7:0] = d;
            HDR_WIDTH_HI:      image_width[15:8] = d;
            HDR_HEIGHT_LO:     image_height[7:0] = d;
            HDR_HEIGHT_HI:     image_height[15:8] = d;
            HDR_DEPTH: begin
              if (d == DEPTH_24 || d == DEPTH_32) begin
                bits_per_pixel = d[5:0];
              end else begin
                bits_per_pixel = '0;
                rejected       = 1'b1;
              end
            end
            HDR_DESCRIPTOR: begin
              top_down = d[DESC_TOP_DOWN_BIT];
              if (rejected) begin
                state = ST_DONE;
                headers_rejected++;
                queue_result(KIND_HEADER_REJECT, '0, '0, '0, '0, '0, 1'b0, 1'b1);
              end else begin
                empty_image = (image_width == 16'd0) || (image_height == 16'd0);
                headers_accepted++;
                queue_result(KIND_HEADER_OK, '0, '0, '0, '0, '0, alpha_on(), empty_image);
                if (empty_image) begin
                  state = ST_DONE;
                end else if (id_length != 8'd0) begin
                  skip_left = id_length;
                  state     = ST_SKIP;
                end else begin
                  start_pixels();
                end
              end
            end
            default: ;
          endcase
          return 1'b1;
        end
        ST_SKIP: begin
          skip_left = skip_left - 8'd1;
          if (skip_left == 8'd0) start_pixels();
          return 1'b1;
        end
        ST_PIXELS: begin
          case (group_position)
            2'd0: begin
              held_blue      = d;
              group_position = 2'd1;
            end
            2'd1: begin
              held_green     = d;
              group_position = 2'd2;
            end
            default: begin
              alpha_byte = '0;
              if (group_position == 2'd2) begin
                held_red = d;
              end else begin
                alpha_byte = d;
              end
              if (group_position == 2'd2 && alpha_on()) begin
                group_position = 2'd3;
              end else begin
                group_position = 2'd0;
                final_pixel    = 1'b0;
                idx            = row_base + 32'(column);
                column         = column + 16'd1;
                if (column == image_width) begin
                  column    = '0;
                  rows_left = rows_left - 16'd1;
                  if (top_down) begin
                    row_base = row_base + 32'(image_width);
                  end else begin
                    row_base = row_base - 32'(image_width);
                  end
                  if (rows_left == 16'd0) begin
                    final_pixel = 1'b1;
                    state       = ST_DONE;
                  end
                end
                pixels_expected++;
                queue_result(KIND_PIXEL, idx, held_red, held_green, held_blue, alpha_byte,
                             alpha_on(), final_pixel);
              end
            end
          endcase
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function string describe(result_beat_t r);
      return $sformatf("kind=%0d idx=%0d rgba=%02h%02h%02h%02h with_alpha=%0b %0dx%0d last=%0b",
                       r.kind, r.pixel_index, r.red, r.green, r.blue, r.alpha, r.with_alpha,
                       r.width, r.height, r.last);
    endfunction

    function void check_result(result_beat_t got);
      result_beat_t want;
      logic         bad;
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result beat: %s", describe(got));
        end
        return;
      end
      want = expected_results.pop_front();
      bad  = (got.kind !== want.kind) || (got.pixel_index !== want.pixel_index) ||
             (got.red !== want.red) || (got.green !== want.green) ||
             (got.blue !== want.blue) || (got.alpha !== want.alpha) ||
             (got.with_alpha !== want.with_alpha) || (got.width !== want.width) ||
             (got.height !== want.height) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch", results_checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_beat_t   byte_beat = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_beat_t result_beat;

  pixel_scoreboard sb = new();

  // Idling percentages for the current phase; the receiver's long hold-off overrides its roll.
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int hold_left         = 0;
  int bytes_used        = 0;
  int bytes_sent        = 0;
  int files_sent        = 0;

  tga_truecolor_unpacker dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver changes its stall on the falling edge. A pending hold-off is counted down
  // here on each falling edge, so the stimulus side only has to request it.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall = 1'b1;
      hold_left    = hold_left - 1;
    end else begin
      result_stall = ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Every result beat that the block hands over is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result_beat);
  end

  // Offers one byte beat, after a random number of idle cycles, and holds it until accepted.
  // Called and returning on a falling edge; valid stays high into the next beat when there
  // is no gap, so it is never dropped and raised within one time step.
  task automatic send_byte(input logic [7:0] d, input logic f);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_valid = 1'b0;
      @(negedge clk);
    end
    byte_valid           = 1'b1;
    byte_beat.data_byte  = d;
    byte_beat.first_byte = f;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    if (sb.note_byte(byte_beat)) bytes_used++;
    @(negedge clk);
  endtask

  // Sends a header of hdr_len bytes built from the given fields, then body_len random bytes
  // that serve as ID field, pixel groups and trailing bytes, in that order.
  task automatic send_file(input logic [7:0] id_len, input logic [7:0] cmap,
                           input logic [7:0] itype, input logic [15:0] w, input logic [15:0] h,
                           input logic [7:0] depth, input logic [7:0] desc,
                           input int hdr_len, input int body_len);
    logic [7:0] header [18];
    foreach (header[i]) header[i] = 8'($urandom);
    header[0]              = id_len;
    header[HDR_COLORMAP_TYPE] = cmap;
    header[HDR_IMAGE_TYPE] = itype;
    header[HDR_WIDTH_LO]   = w[7:0];
    header[HDR_WIDTH_HI]   = w[15:8];
    header[HDR_HEIGHT_LO]  = h[7:0];
    header[HDR_HEIGHT_HI]  = h[15:8];
    header[HDR_DEPTH]      = depth;
    header[HDR_DESCRIPTOR] = desc;
    for (int i = 0; i < hdr_len; i++) send_byte(header[i], i == 0);
    for (int i = 0; i < body_len; i++) send_byte(8'($urandom), 1'b0);
    files_sent++;
  endtask

  // Mostly well-formed small images with random pixels; a minority carries a bad header,
  // an empty size, a huge size cut short, a truncated header or extra trailing bytes.
  task automatic send_random_file();
    logic [7:0]  id_len;
    logic [7:0]  cmap;
    logic [7:0]  itype;
    logic [7:0]  depth;
    logic [15:0] w;
    logic [15:0] h;
    int          size_roll;
    int          roll;
    int          body;
    int          hdr_len;
    roll   = $urandom_range(99);
    id_len = (roll < 70) ? 8'd0 : (roll < 97) ? 8'($urandom_range(4, 1)) : 8'($urandom);
    cmap   = ($urandom_range(99) < 92) ? 8'd0 : 8'($urandom_range(255, 1));
    itype  = ($urandom_range(99) < 92) ? IMAGE_TYPE_TRUECOLOR : 8'($urandom);
    size_roll = $urandom_range(99);
    if (size_roll < 85) begin
      w = 16'($urandom_range(6, 1));
      h = 16'($urandom_range(4, 1));
    end else if (size_roll < 90) begin
      w = $urandom_range(1) ? 16'd0 : 16'($urandom_range(6));
      h = (w == 16'd0) ? 16'($urandom_range(6)) : 16'd0;
    end else begin
      w = 16'($urandom);
      h = 16'($urandom);
    end
    roll  = $urandom_range(99);
    depth = (roll < 46) ? DEPTH_24 : (roll < 92) ? DEPTH_32 : 8'($urandom);
    if (size_roll < 85) begin
      body = int'(id_len) + int'(w) * int'(h) * ((depth == DEPTH_32) ? 4 : 3);
    end else begin
      body = int'(id_len) + $urandom_range(30);
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      body = $urandom_range(body);
    end else if (roll < 18) begin
      body = body + $urandom_range(6, 1);
    end
    hdr_len = 18;
    if ($urandom_range(99) < 3) begin
      hdr_len = $urandom_range(17, 1);
      body    = 0;
    end
    send_file(id_len, cmap, itype, w, h, depth, 8'($urandom), hdr_len, body);
  endtask

  task automatic wait_for_results();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Phase 0 has no idling, 1 an idle sender, 2 a stalling receiver, 3 both lightly.
  task automatic set_idling(input int phase_no);
    case (phase_no)
      1:       begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
      2:       begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
      3:       begin sender_idle_pct = 17; receiver_stall_pct = 17; end
      default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
    endcase
  endtask

  initial begin
    int drain_cycles;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed files. Stray bytes before any file must be dropped.
    set_idling(0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Rejections: color map present, wrong image type, unsupported depth. The first one also
    // carries the widest width and a zero height, and is followed by ignored bytes.
    send_file(8'd0, 8'h01, IMAGE_TYPE_TRUECOLOR, 16'hFFFF, 16'h0000, DEPTH_24, 8'h00, 18, 2);
    send_file(8'd0, 8'h00, 8'hFF, 16'h0001, 16'hFFFF, DEPTH_32, 8'hFF, 18, 0);
    send_file(8'd0, 8'h00, IMAGE_TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd16, 8'h20, 18, 1);
    // A header cut short by the next file.
    send_file(8'd0, 8'h00, IMAGE_TYPE_TRUECOLOR, 16'd3, 16'd2, DEPTH_24, 8'h00, 5, 0);
    // Empty image: header beat with last, then the ID field and everything else is dropped.
    send_file(8'd3, 8'h00, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd5, DEPTH_32, 8'h00, 18, 4);
    // Bottom-up 24-bit image behind a two-byte ID field, with trailing bytes.
    send_file(8'd2, 8'h00, IMAGE_TYPE_TRUECOLOR, 16'd3, 16'd2, DEPTH_24, 8'h00, 18, 22);
    // Top-down 32-bit image.
    send_file(8'd0, 8'h00, IMAGE_TYPE_TRUECOLOR, 16'd2, 16'd2, DEPTH_32, 8'h20, 18, 16);
    // Largest bottom-up image, restarted after three pixels.
    send_file(8'd0, 8'h00, IMAGE_TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_24, 8'h00, 18, 9);
    // Longest ID field in front of a single pixel.
    send_file(8'hFF, 8'h00, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_32, 8'h20, 18, 259);

    // Back-pressure: the receiver holds off while the sender keeps offering, so the internal
    // queue and output register fill and the byte side must stall. Then the sender waits for
    // everything to come out.
    hold_left = 150;
    send_file(8'd0, 8'h00, IMAGE_TYPE_TRUECOLOR, 16'd5, 16'd4, DEPTH_32, 8'h00, 18, 80);
    byte_valid = 1'b0;
    wait_for_results();

    // Random files, changing the idling pattern every four files at a quiet point.
    while (bytes_sent < TARGET_BYTES) begin
      if (files_sent % 4 == 0) begin
        byte_valid = 1'b0;
        wait_for_results();
        set_idling((files_sent / 4) % 4);
      end
      send_random_file();
    end
    byte_valid = 1'b0;

    // Let the remaining beats drain, then keep watching to catch anything spurious.
    drain_cycles = 0;
    while (sb.pending() != 0 && drain_cycles < 5000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("ERROR: %0d expected results never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("Run covered %0d files, %0d byte beats (%0d parsed) under four idling patterns.",
             files_sent, bytes_sent, bytes_used);
    $display("Checked %0d beats: %0d accepted headers, %0d rejected headers, %0d pixels.",
             sb.results_checked, sb.headers_accepted, sb.headers_rejected,
             sb.pixels_expected);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("ERROR: timeout with %0d results outstanding", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
